// File: rtl/core/fpdd_pkg.sv
// ----------------------------------------------------------------------------
// fpdd_pkg
// Shared types and constants for the double-precision divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpdd_pkg;

    localparam int WordW = 64;
    localparam int SigW  = 61;
    localparam int ExpW  = 13;
    localparam int CntW  = 6;

    localparam logic [10:0] ExpAllOnes = 11'h7ff;
    localparam logic [WordW-1:0] SignBit = 64'h8000_0000_0000_0000;
    localparam logic [WordW-1:0] InfBits = 64'h7ff0_0000_0000_0000;
    localparam logic [WordW-1:0] QnanBits = 64'hfff8_0000_0000_0000;
    localparam logic [CntW-1:0] LastBit = 6'd60;

    typedef enum logic [1:0] {
        CL_ZERO = 2'd0,
        CL_NUM  = 2'd1,
        CL_INF  = 2'd2,
        CL_NAN  = 2'd3
    } t_class;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_NORM = 3'd1,
        ST_PREP = 3'd2,
        ST_DIV  = 3'd3,
        ST_RND  = 3'd4,
        ST_PACK = 3'd5
    } t_state;

    typedef struct packed {
        logic load;
        logic norm;
        logic prep;
        logic div;
        logic rnd;
        logic pack;
    } t_cmd;

    typedef struct packed {
        logic special;
        logic norm_done;
        logic div_last;
    } t_status;

endpackage

// File: rtl/core/fpdd_ctrl.sv
// ----------------------------------------------------------------------------
// fpdd_ctrl
// Sequencer: load, normalize, prep, divide, round and pack steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpdd_ctrl
    import fpdd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_NORM;
            end
            ST_NORM: begin
                if (i_status.special) n_state = ST_PACK;
                else if (i_status.norm_done) n_state = ST_PREP;
            end
            ST_PREP: n_state = ST_DIV;
            ST_DIV: begin
                if (i_status.div_last) n_state = ST_RND;
            end
            ST_RND:  n_state = ST_PACK;
            ST_PACK: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_NORM: o_cmd.norm = 1'b1;
            ST_PREP: o_cmd.prep = 1'b1;
            ST_DIV:  o_cmd.div  = 1'b1;
            ST_RND:  o_cmd.rnd  = 1'b1;
            ST_PACK: o_cmd.pack = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted word did not raise busy");
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_status.div_last) |=> (r_state == ST_RND))
        else $error("divide did not end in round step");
    a_pack_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pack |=> !o_busy)
        else $error("pack step not followed by idle");

endmodule

// File: rtl/core/fpdd_datapath.sv
// ----------------------------------------------------------------------------
// fpdd_datapath
// Unpack, normalize, restoring divide, rounding and packing registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpdd_datapath
    import fpdd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [WordW-1:0] i_dividend,
    input  logic [WordW-1:0] i_divisor,
    output t_status          o_status,
    output logic [WordW-1:0] o_quotient,
    output logic             o_valid
);

    logic                   r_special;
    logic [WordW-1:0]       r_spec_val;
    logic                   r_sign;
    logic signed [ExpW-1:0] r_a_ex, r_b_ex, r_ex;
    logic [SigW-1:0]        r_a_sig, r_b_sig;
    logic [SigW:0]          r_num;
    logic [SigW-1:0]        r_q;
    logic [SigW:0]          r_qr;
    logic [CntW-1:0]        r_cnt;
    logic [WordW-1:0]       r_res;
    logic                   r_valid;

    logic [10:0] a_e, b_e;
    logic [51:0] a_f, b_f;
    t_class      a_cl, b_cl;
    logic [WordW-1:0] spec_val;
    logic        spec;

    assign a_e = i_dividend[62:52];
    assign b_e = i_divisor[62:52];
    assign a_f = i_dividend[51:0];
    assign b_f = i_divisor[51:0];

    function automatic t_class classify(input logic [10:0] e, input logic [51:0] f);
        if (e == 11'd0) return (f == 52'd0) ? CL_ZERO : CL_NUM;
        if (e == ExpAllOnes) return (f == 52'd0) ? CL_INF : CL_NAN;
        return CL_NUM;
    endfunction

    function automatic logic signed [ExpW-1:0] unb_ex(input logic [10:0] e);
        if (e == 11'd0) return -13'sd1022;
        return $signed({2'b00, e}) - 13'sd1023;
    endfunction

    assign a_cl = classify(a_e, a_f);
    assign b_cl = classify(b_e, b_f);

    always_comb begin
        spec     = 1'b1;
        spec_val = '0;
        if (a_cl == CL_NAN) begin
            spec_val = i_dividend | SignBit;
        end else if (b_cl == CL_NAN) begin
            spec_val = i_divisor | SignBit;
        end else if (a_cl == CL_INF || a_cl == CL_ZERO) begin
            spec_val = (a_cl == b_cl) ? QnanBits : i_dividend;
        end else if (b_cl == CL_INF) begin
            spec_val = (i_dividend ^ i_divisor) & SignBit;
        end else if (b_cl == CL_ZERO) begin
            spec_val = ((i_dividend ^ i_divisor) & SignBit) | InfBits;
        end else begin
            spec = 1'b0;
        end
    end

    // divide step
    logic [SigW:0] den_ext;
    logic          ge;
    logic [SigW:0] diff;
    assign den_ext = {1'b0, r_b_sig};
    assign ge      = r_num >= den_ext;
    assign diff    = ge ? (r_num - den_ext) : r_num;

    // first rounding stage
    logic [SigW:0] q_rnd;
    always_comb begin
        q_rnd = {1'b0, r_q};
        if (r_q[7:0] == 8'h80 && (r_q[8] || r_num != '0)) q_rnd = q_rnd + 62'h80;
    end

    // pack
    logic signed [ExpW-1:0] sh;
    logic [SigW:0]          q_sub;
    logic [SigW:0]          q_n;
    logic [10:0]            e_n;
    logic [WordW-1:0]       sgn;
    logic [WordW-1:0]       pack_val;
    assign sh  = -13'sd1022 - r_ex;
    assign sgn = r_sign ? SignBit : '0;
    always_comb begin
        q_sub = '0;
        q_n   = r_qr;
        e_n   = 11'(r_ex + 13'sd1023);
        if (r_qr[7:0] == 8'h80) begin
            if (r_qr[8]) q_n = r_qr + 62'h80;
        end else begin
            q_n = r_qr + 62'h7f;
        end
        if (q_n[SigW]) begin
            q_n = q_n >> 1;
            e_n = e_n + 11'd1;
        end
        if (r_ex < -13'sd1022) begin
            if (sh > 13'sd56) begin
                pack_val = sgn;
            end else begin
                q_sub    = (r_qr >> sh[5:0]) >> 8;
                pack_val = sgn | {2'b00, q_sub};
            end
        end else if (r_ex > 13'sd1023) begin
            pack_val = sgn | InfBits;
        end else begin
            pack_val = sgn | {1'b0, e_n, q_n[59:8]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_special  <= spec;
            r_spec_val <= spec_val;
            r_sign     <= i_dividend[63] ^ i_divisor[63];
            r_a_ex     <= unb_ex(a_e);
            r_b_ex     <= unb_ex(b_e);
            r_a_sig    <= {(a_e != 11'd0), a_f, 8'h00};
            r_b_sig    <= {(b_e != 11'd0), b_f, 8'h00};
        end
        if (i_cmd.norm) begin
            if (!r_a_sig[SigW-1]) begin
                r_a_sig <= r_a_sig << 1;
                r_a_ex  <= r_a_ex - 13'sd1;
            end
            if (!r_b_sig[SigW-1]) begin
                r_b_sig <= r_b_sig << 1;
                r_b_ex  <= r_b_ex - 13'sd1;
            end
        end
        if (i_cmd.prep) begin
            r_cnt <= LastBit;
            r_q   <= '0;
            if (r_a_sig < r_b_sig) begin
                r_num <= {r_a_sig, 1'b0};
                r_ex  <= r_a_ex - r_b_ex - 13'sd1;
            end else begin
                r_num <= {1'b0, r_a_sig};
                r_ex  <= r_a_ex - r_b_ex;
            end
        end
        if (i_cmd.div) begin
            r_q   <= {r_q[SigW-2:0], ge};
            r_num <= {diff[SigW-1:0], 1'b0};
            r_cnt <= r_cnt - 6'd1;
        end
        if (i_cmd.rnd) r_qr <= q_rnd;
        if (i_cmd.pack) r_res <= r_special ? r_spec_val : pack_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.pack;
        end
    end

    assign o_status.special   = r_special;
    assign o_status.norm_done = r_a_sig[SigW-1] && r_b_sig[SigW-1];
    assign o_status.div_last  = (r_cnt == '0);
    assign o_quotient         = r_res;
    assign o_valid            = r_valid;

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe longer than one cycle");
    a_norm_hidden: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.prep |-> (r_a_sig[SigW-1] && r_b_sig[SigW-1]))
        else $error("divide started on unnormalized significand");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div |=> (r_num[SigW:1] < {1'b0, r_b_sig}))
        else $error("partial remainder out of range");

endmodule

// File: rtl/core/fp_double_divide_core.sv
// ----------------------------------------------------------------------------
// fp_double_divide_core
// IEEE 754 double-precision divider, restoring radix-2, one quotient a word.
// ----------------------------------------------------------------------------
//  channel  | handshake              | ports
//  ---------+------------------------+---------------------------------
//  input    | i_start & !o_busy      | i_dividend, i_divisor
//  result   | o_valid (one cycle)    | o_quotient
//
//  Finite operands pass through load, normalize, prep, divide, round and
//  pack steps; the subnormal normalize loop and the one-bit-per-cycle
//  divide loop set the run time. Special operands go from normalize to pack.
//  Reset is synchronous, active low; the receiver cannot stall the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fp_double_divide_core
    import fpdd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  logic [WordW-1:0] i_dividend,
    input  logic [WordW-1:0] i_divisor,
    output logic [WordW-1:0] o_quotient,
    output logic             o_valid
);

    t_cmd    cmd;
    t_status status;

    fpdd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    fpdd_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_status   (status),
        .o_quotient (o_quotient),
        .o_valid    (o_valid)
    );

endmodule
